### rtl/psd_pkg.sv
// ----------------------------------------------------------------------------
// psd_pkg - shared constants and types of the point/segment distance unit
// Widths, pipeline stage numbers and the item structures used by all files.
// ----------------------------------------------------------------------------
package psd_pkg;

	localparam int CW      = 32;             // coordinate width
	localparam int W_W     = CW + 1;         // base minus point
	localparam int E_W     = CW + 2;         // far end minus point
	localparam int IN_W    = 9 * CW;
	localparam int OUT_W   = 4 * CW;
	localparam int USER_W  = 3;

	localparam int MUL_W   = 2 * CW + 4;     // multiplier operand, signed
	localparam int PROD_W  = 2 * MUL_W;
	localparam int MUL_CH  = 24;             // partial product slice
	localparam int MUL_N   = (MUL_W + MUL_CH - 1) / MUL_CH;
	localparam int MUL_LAT = 5;

	localparam int SQ_W    = 2 * CW + 6;     // squared lengths, radicand
	localparam int ROOT_W  = SQ_W / 2;
	localparam int DEN_W   = 2 * CW + 1;
	localparam int QUO_W   = 2 * CW + 4;
	localparam int NUM_W   = DEN_W + 1 + QUO_W;
	localparam int NV_W    = QUO_W + 1;

	localparam int ST_IN   = 1;
	localparam int ST_M1   = ST_IN + MUL_LAT;
	localparam int ST_SUM  = ST_M1 + 1;
	localparam int ST_M2   = ST_SUM + MUL_LAT;
	localparam int ST_NUM  = ST_M2 + 1;
	localparam int ST_DIV  = ST_NUM + 1;
	localparam int ST_QUO  = ST_DIV + QUO_W;
	localparam int ST_SEL  = ST_QUO + 1;
	localparam int ST_ROOT = ST_SEL + ROOT_W;
	localparam int ST_OUT  = ST_ROOT + 1;

	typedef enum logic [1:0] {
		REG_PERP = 2'd0,
		REG_FAR  = 2'd1,
		REG_BASE = 2'd2,
		REG_ZERO = 2'd3
	} region_t;

	typedef struct packed {
		logic [2:0][W_W-1:0] w;
		logic [2:0][CW-1:0]  a;
		logic [2:0][E_W-1:0] e;
	} geo_t;

	typedef struct packed {
		logic [SQ_W-1:0] d1;
		logic [SQ_W-1:0] d2;
		logic [SQ_W-1:0] d3;
	} sq_t;

	typedef struct packed {
		logic                sat;
		region_t             region;
		logic [2:0][CW-1:0]  near;
		logic [CW-1:0]       distance;
	} res_t;

endpackage

### rtl/psd_mul.sv
// ----------------------------------------------------------------------------
// psd_mul - pipelined signed multiplier
// Sign/magnitude, narrow slice products, row sums, total, sign. Five stages.
// ----------------------------------------------------------------------------
module psd_mul (
	input  logic                        clk,
	input  logic                        en,
	input  logic [psd_pkg::MUL_W-1:0]   a,
	input  logic [psd_pkg::MUL_W-1:0]   b,
	output logic [psd_pkg::PROD_W-1:0]  p
);
	localparam int PAD_W = psd_pkg::MUL_N * psd_pkg::MUL_CH;

	logic [psd_pkg::MUL_W-1:0]    mag_a, mag_b;
	logic                         neg_s1, neg_s2, neg_s3, neg_s4;
	logic [PAD_W-1:0]             ma_s1, mb_s1;
	logic [2*psd_pkg::MUL_CH-1:0] pp_s2 [psd_pkg::MUL_N][psd_pkg::MUL_N];
	logic [psd_pkg::PROD_W-1:0]   row_c [psd_pkg::MUL_N];
	logic [psd_pkg::PROD_W-1:0]   row_s3 [psd_pkg::MUL_N];
	logic [psd_pkg::PROD_W-1:0]   sum_c, sum_s4, p_s5;

	assign mag_a = a[psd_pkg::MUL_W-1] ? -a : a;
	assign mag_b = b[psd_pkg::MUL_W-1] ? -b : b;

	always_comb begin
		for (int i = 0; i < psd_pkg::MUL_N; i++) begin
			row_c[i] = '0;
			for (int j = 0; j < psd_pkg::MUL_N; j++) begin
				row_c[i] = row_c[i]
					+ (psd_pkg::PROD_W'(pp_s2[i][j]) << (j * psd_pkg::MUL_CH));
			end
		end
		sum_c = '0;
		for (int i = 0; i < psd_pkg::MUL_N; i++) begin
			sum_c = sum_c + (row_s3[i] << (i * psd_pkg::MUL_CH));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= a[psd_pkg::MUL_W-1] ^ b[psd_pkg::MUL_W-1];
			ma_s1  <= PAD_W'(mag_a);
			mb_s1  <= PAD_W'(mag_b);
			neg_s2 <= neg_s1;
			for (int i = 0; i < psd_pkg::MUL_N; i++) begin
				for (int j = 0; j < psd_pkg::MUL_N; j++) begin
					pp_s2[i][j] <= ma_s1[i*psd_pkg::MUL_CH +: psd_pkg::MUL_CH]
						* mb_s1[j*psd_pkg::MUL_CH +: psd_pkg::MUL_CH];
				end
			end
			neg_s3 <= neg_s2;
			row_s3 <= row_c;
			neg_s4 <= neg_s3;
			sum_s4 <= sum_c;
			p_s5   <= neg_s4 ? -sum_s4 : sum_s4;
		end
	end

	assign p = p_s5;
endmodule

### rtl/psd_div.sv
// ----------------------------------------------------------------------------
// psd_div - pipelined restoring divider
// One quotient bit per stage; the numerator's top part is below the divisor.
// ----------------------------------------------------------------------------
module psd_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [psd_pkg::NUM_W-1:0]  num,
	input  logic [psd_pkg::DEN_W-1:0]  den,
	output logic [psd_pkg::QUO_W-1:0]  quo
);
	localparam int RW = psd_pkg::DEN_W + 1;
	localparam int QW = psd_pkg::QUO_W;

	logic [RW-1:0]              rem_s [0:QW-1];
	logic [QW-1:0]              low_s [0:QW-1];
	logic [psd_pkg::DEN_W-1:0]  den_s [0:QW-1];
	logic [QW-1:0]              q_s   [0:QW];

	assign rem_s[0] = num[psd_pkg::NUM_W-1:QW];
	assign low_s[0] = num[QW-1:0];
	assign den_s[0] = den;
	assign q_s[0]   = '0;

	for (genvar k = 1; k <= QW; k++) begin : g_stage
		logic [RW:0] cur_c, dif_c;
		logic        take_c;

		always_comb begin
			cur_c  = {rem_s[k-1], low_s[k-1][QW-1]};
			dif_c  = cur_c - (RW+1)'(den_s[k-1]);
			take_c = !dif_c[RW];
		end

		always_ff @(posedge clk) begin
			if (en) q_s[k] <= {q_s[k-1][QW-2:0], take_c};
		end

		if (k < QW) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take_c ? dif_c[RW-1:0] : cur_c[RW-1:0];
					low_s[k] <= low_s[k-1] << 1;
					den_s[k] <= den_s[k-1];
				end
			end
		end
	end

	assign quo = q_s[QW];
endmodule

### rtl/psd_sqrt.sv
// ----------------------------------------------------------------------------
// psd_sqrt - pipelined integer square root, rounded down
// Two radicand bits and one root bit per stage.
// ----------------------------------------------------------------------------
module psd_sqrt (
	input  logic                        clk,
	input  logic                        en,
	input  logic [psd_pkg::SQ_W-1:0]    rad,
	output logic [psd_pkg::ROOT_W-1:0]  root
);
	localparam int RN = psd_pkg::ROOT_W;
	localparam int RW = RN + 2;
	localparam int SW = psd_pkg::SQ_W;

	logic [RW-1:0] rem_s  [0:RN-1];
	logic [SW-1:0] low_s  [0:RN-1];
	logic [RN-1:0] root_s [0:RN];

	assign rem_s[0]  = '0;
	assign low_s[0]  = rad;
	assign root_s[0] = '0;

	for (genvar k = 1; k <= RN; k++) begin : g_stage
		logic [RW-1:0] cur_c, trial_c;
		logic          take_c;

		always_comb begin
			cur_c   = {rem_s[k-1][RW-3:0], low_s[k-1][SW-1:SW-2]};
			trial_c = {root_s[k-1], 2'b01};
			take_c  = cur_c >= trial_c;
		end

		always_ff @(posedge clk) begin
			if (en) root_s[k] <= {root_s[k-1][RN-2:0], take_c};
		end

		if (k < RN) begin : g_fwd
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k] <= take_c ? cur_c - trial_c : cur_c;
					low_s[k] <= low_s[k-1] << 2;
				end
			end
		end
	end

	assign root = root_s[RN];
endmodule

### rtl/point_segment_distance_unit.sv
// ----------------------------------------------------------------------------
// point_segment_distance_unit - 3D point to segment / line distance
// Signed Q16.16 query point, base and direction in; distance, vector from the
// point to the nearest point, region and saturation flag out.
//
//   channel   dir  signals                         payload
//   s_axis    in   tvalid tready tdata[287:0]      point, base, dir xyz
//   m_axis    out  tvalid tready tdata tuser       distance, near xyz; region, sat
//   cfg       in   cfg_wr_en cfg_wr_data           segment_mode
//
// One item per cycle while the skid register is empty. The longest parts of the
// pipeline are the 68 stage divider and the 35 stage square root.
// Reset clears valid bits and sets segment_mode to 1.
// A held output parks the next item in a skid register; s_axis_tready then
// drops and the whole pipeline freezes until the skid register drains.
// ----------------------------------------------------------------------------
module point_segment_distance_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic                          cfg_wr_data,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// point_x, point_y, point_z, base_x, base_y, base_z, dir_x, dir_y, dir_z
	input  logic [psd_pkg::IN_W-1:0]      s_axis_tdata,
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// distance, near_x, near_y, near_z
	output logic [psd_pkg::OUT_W-1:0]     m_axis_tdata,
	// region[1:0], saturated
	output logic [psd_pkg::USER_W-1:0]    m_axis_tuser
);
	localparam int CW = psd_pkg::CW;

	logic mode_q, en;
	logic skid_v_q, out_v_q;
	psd_pkg::res_t out_q, skid_q, res_c;

	logic              vld_s [psd_pkg::ST_IN:psd_pkg::ST_OUT];
	psd_pkg::geo_t     geo_s [psd_pkg::ST_IN:psd_pkg::ST_QUO];
	psd_pkg::sq_t      sq_s  [psd_pkg::ST_SUM:psd_pkg::ST_QUO];
	psd_pkg::region_t  reg_s [psd_pkg::ST_NUM:psd_pkg::ST_ROOT];
	logic [2:0]        neg_s [psd_pkg::ST_DIV:psd_pkg::ST_QUO];
	logic [2:0][psd_pkg::NV_W-1:0] nv_s [psd_pkg::ST_SEL:psd_pkg::ST_ROOT];

	psd_pkg::geo_t  geo_c;
	psd_pkg::sq_t   sq_c;
	psd_pkg::region_t reg_c;

	logic [psd_pkg::MUL_W-1:0]  m1a [18], m1b [18], m2a [9], m2b [9];
	logic [psd_pkg::PROD_W-1:0] m1p [18], m2p [9];

	logic [2:0][psd_pkg::MUL_W-1:0] c_s7;
	logic [psd_pkg::MUL_W-1:0]      aw_s7;
	logic [psd_pkg::NUM_W-1:0]      cc_s13;
	logic [2:0][psd_pkg::NUM_W-1:0] num_s13;
	logic [psd_pkg::NUM_W-1:0]      dn_s14 [4];
	logic [psd_pkg::DEN_W-1:0]      den_s14;
	logic [psd_pkg::QUO_W-1:0]      quo [4];
	logic [psd_pkg::SQ_W-1:0]       rad_s83, rad_c;
	logic [2:0][psd_pkg::NV_W-1:0]  nv_c;
	logic [psd_pkg::ROOT_W-1:0]     root;
	logic [psd_pkg::SQ_W:0]         far_sum_c, base_sum_c;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_wr_en) begin
			mode_q <= cfg_wr_data;
		end
	end

	assign en            = !skid_v_q;
	assign s_axis_tready = en;

	// input stage
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			geo_c.w[i] = psd_pkg::W_W'(signed'(s_axis_tdata[(3+i)*CW +: CW]))
				- psd_pkg::W_W'(signed'(s_axis_tdata[i*CW +: CW]));
			geo_c.a[i] = s_axis_tdata[(6+i)*CW +: CW];
			geo_c.e[i] = psd_pkg::E_W'(signed'(geo_c.w[i]))
				+ psd_pkg::E_W'(signed'(geo_c.a[i]));
		end
	end

	// first multiplier layer: squares, dot a.w, cross product terms
	for (genvar i = 0; i < 3; i++) begin : g_l1
		assign m1a[i]      = psd_pkg::MUL_W'(signed'(geo_s[psd_pkg::ST_IN].w[i]));
		assign m1b[i]      = m1a[i];
		assign m1a[3+i]    = psd_pkg::MUL_W'(signed'(geo_s[psd_pkg::ST_IN].a[i]));
		assign m1b[3+i]    = m1a[3+i];
		assign m1a[6+i]    = psd_pkg::MUL_W'(signed'(geo_s[psd_pkg::ST_IN].e[i]));
		assign m1b[6+i]    = m1a[6+i];
		assign m1a[9+i]    = m1a[i];
		assign m1b[9+i]    = m1a[3+i];
		assign m1a[12+2*i] = m1a[(i+1)%3];
		assign m1b[12+2*i] = m1a[3+(i+2)%3];
		assign m1a[13+2*i] = m1a[(i+2)%3];
		assign m1b[13+2*i] = m1a[3+(i+1)%3];
	end

	for (genvar k = 0; k < 18; k++) begin : g_m1
		psd_mul u_mul (.clk(clk), .en(en), .a(m1a[k]), .b(m1b[k]), .p(m1p[k]));
	end

	always_comb begin
		sq_c.d1 = psd_pkg::SQ_W'(m1p[0] + m1p[1] + m1p[2]);
		sq_c.d3 = psd_pkg::SQ_W'(m1p[3] + m1p[4] + m1p[5]);
		sq_c.d2 = psd_pkg::SQ_W'(m1p[6] + m1p[7] + m1p[8]);
	end

	// second multiplier layer: |c|^2 terms, w*d3, a*(a.w)
	for (genvar i = 0; i < 3; i++) begin : g_l2
		assign m2a[i]   = c_s7[i];
		assign m2b[i]   = c_s7[i];
		assign m2a[3+i] = psd_pkg::MUL_W'(signed'(geo_s[psd_pkg::ST_SUM].w[i]));
		assign m2b[3+i] = psd_pkg::MUL_W'(sq_s[psd_pkg::ST_SUM].d3);
		assign m2a[6+i] = psd_pkg::MUL_W'(signed'(geo_s[psd_pkg::ST_SUM].a[i]));
		assign m2b[6+i] = aw_s7;
	end

	for (genvar k = 0; k < 9; k++) begin : g_m2
		psd_mul u_mul (.clk(clk), .en(en), .a(m2a[k]), .b(m2b[k]), .p(m2p[k]));
	end

	// region test
	always_comb begin
		far_sum_c  = (psd_pkg::SQ_W+1)'(sq_s[psd_pkg::ST_M2].d2)
			+ (psd_pkg::SQ_W+1)'(sq_s[psd_pkg::ST_M2].d3);
		base_sum_c = (psd_pkg::SQ_W+1)'(sq_s[psd_pkg::ST_M2].d1)
			+ (psd_pkg::SQ_W+1)'(sq_s[psd_pkg::ST_M2].d3);
		priority if (sq_s[psd_pkg::ST_M2].d3 == '0) begin
			reg_c = psd_pkg::REG_ZERO;
		end else if (mode_q && far_sum_c < (psd_pkg::SQ_W+1)'(sq_s[psd_pkg::ST_M2].d1)) begin
			reg_c = psd_pkg::REG_FAR;
		end else if (mode_q && base_sum_c < (psd_pkg::SQ_W+1)'(sq_s[psd_pkg::ST_M2].d2)) begin
			reg_c = psd_pkg::REG_BASE;
		end else begin
			reg_c = psd_pkg::REG_PERP;
		end
	end

	// dividers: |c|^2 / d3 and the three vector numerators / d3
	for (genvar k = 0; k < 4; k++) begin : g_div
		psd_div u_div (.clk(clk), .en(en), .num(dn_s14[k]), .den(den_s14), .quo(quo[k]));
	end

	// pick radicand and vector per region
	always_comb begin
		unique case (reg_s[psd_pkg::ST_QUO])
			psd_pkg::REG_PERP: begin
				rad_c = psd_pkg::SQ_W'(quo[0]);
				for (int i = 0; i < 3; i++) begin
					nv_c[i] = neg_s[psd_pkg::ST_QUO][i] ? -psd_pkg::NV_W'(quo[i+1])
						: psd_pkg::NV_W'(quo[i+1]);
				end
			end
			psd_pkg::REG_FAR: begin
				rad_c = sq_s[psd_pkg::ST_QUO].d2;
				for (int i = 0; i < 3; i++) begin
					nv_c[i] = psd_pkg::NV_W'(signed'(geo_s[psd_pkg::ST_QUO].e[i]));
				end
			end
			psd_pkg::REG_BASE, psd_pkg::REG_ZERO: begin
				rad_c = sq_s[psd_pkg::ST_QUO].d1;
				for (int i = 0; i < 3; i++) begin
					nv_c[i] = psd_pkg::NV_W'(signed'(geo_s[psd_pkg::ST_QUO].w[i]));
				end
			end
		endcase
	end

	psd_sqrt u_sqrt (.clk(clk), .en(en), .rad(rad_s83), .root(root));

	// saturation
	always_comb begin
		logic [psd_pkg::NV_W-CW:0] hi;
		res_c.sat      = |root[psd_pkg::ROOT_W-1:CW];
		res_c.distance = res_c.sat ? '1 : root[CW-1:0];
		res_c.region   = reg_s[psd_pkg::ST_ROOT];
		for (int i = 0; i < 3; i++) begin
			hi = nv_s[psd_pkg::ST_ROOT][i][psd_pkg::NV_W-1:CW-1];
			if ((&hi) || !(|hi)) begin
				res_c.near[i] = nv_s[psd_pkg::ST_ROOT][i][CW-1:0];
			end else begin
				res_c.sat     = 1'b1;
				res_c.near[i] = hi[psd_pkg::NV_W-CW] ? {1'b1, {(CW-1){1'b0}}}
					: {1'b0, {(CW-1){1'b1}}};
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (en) begin
			geo_s[psd_pkg::ST_IN] <= geo_c;
			for (int k = psd_pkg::ST_IN + 1; k <= psd_pkg::ST_QUO; k++) geo_s[k] <= geo_s[k-1];

			sq_s[psd_pkg::ST_SUM] <= sq_c;
			for (int k = psd_pkg::ST_SUM + 1; k <= psd_pkg::ST_QUO; k++) sq_s[k] <= sq_s[k-1];
			for (int i = 0; i < 3; i++) begin
				c_s7[i] <= psd_pkg::MUL_W'(m1p[12+2*i] - m1p[13+2*i]);
			end
			aw_s7 <= psd_pkg::MUL_W'(m1p[9] + m1p[10] + m1p[11]);

			cc_s13 <= psd_pkg::NUM_W'(m2p[0] + m2p[1] + m2p[2]);
			for (int i = 0; i < 3; i++) begin
				num_s13[i] <= psd_pkg::NUM_W'(m2p[3+i] - m2p[6+i]);
			end
			reg_s[psd_pkg::ST_NUM] <= reg_c;
			for (int k = psd_pkg::ST_NUM + 1; k <= psd_pkg::ST_ROOT; k++) reg_s[k] <= reg_s[k-1];

			dn_s14[0] <= cc_s13;
			for (int i = 0; i < 3; i++) begin
				dn_s14[i+1] <= num_s13[i][psd_pkg::NUM_W-1] ? -num_s13[i] : num_s13[i];
				neg_s[psd_pkg::ST_DIV][i] <= num_s13[i][psd_pkg::NUM_W-1];
			end
			den_s14 <= sq_s[psd_pkg::ST_NUM].d3[psd_pkg::DEN_W-1:0];
			for (int k = psd_pkg::ST_DIV + 1; k <= psd_pkg::ST_QUO; k++) neg_s[k] <= neg_s[k-1];

			rad_s83 <= rad_c;
			nv_s[psd_pkg::ST_SEL] <= nv_c;
			for (int k = psd_pkg::ST_SEL + 1; k <= psd_pkg::ST_ROOT; k++) nv_s[k] <= nv_s[k-1];
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = psd_pkg::ST_IN; k <= psd_pkg::ST_OUT; k++) vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[psd_pkg::ST_IN] <= s_axis_tvalid;
			for (int k = psd_pkg::ST_IN + 1; k <= psd_pkg::ST_OUT; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// last stage payload; output register and skid register
	psd_pkg::res_t res_s119;

	always_ff @(posedge clk) begin
		if (en) res_s119 <= res_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_axis_tready) begin
			if (skid_v_q) begin
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= vld_s[psd_pkg::ST_OUT];
			end
		end else if (en && vld_s[psd_pkg::ST_OUT]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_axis_tready) begin
			out_q <= skid_v_q ? skid_q : res_s119;
		end else if (en) begin
			skid_q <= res_s119;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {out_q.near[2], out_q.near[1], out_q.near[0], out_q.distance};
	assign m_axis_tuser  = {out_q.sat, out_q.region};

	// checks
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid register full while output register empty");

	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(out_v_q && !m_axis_tready))
		else $error("skid register filled without a held output");

	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> vld_s[psd_pkg::ST_IN])
		else $error("accepted item missing from first stage");

	a_zero_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s[psd_pkg::ST_NUM] && reg_s[psd_pkg::ST_NUM] == psd_pkg::REG_ZERO)
		|-> sq_s[psd_pkg::ST_NUM].d3 == '0)
		else $error("zero direction region with nonzero length");
endmodule
